[sv/outstanding_ack_tracker_assert.svh]
// assertion macros for the outstanding ack tracker
`ifndef OUTSTANDING_ACK_TRACKER_ASSERT_SVH
`define OUTSTANDING_ACK_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define OAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OAT_ASSERT(lbl, prop, msg)
`define OAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/oat_pkg.sv]
package oat_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_RES = 16;
  localparam int NW = $clog2(MAX_RES + 1);

  localparam logic [1:0] REG_PEER    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_GOOD    = 2'd2;

  localparam logic [7:0]  PEER_RESET    = 8'hF0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    MODE_SENT = 2'd0,
    MODE_ACK  = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_QUEUED    = 3'd0,
    EV_OK        = 3'd1,
    EV_BAD       = 3'd2,
    EV_UNMATCHED = 3'd3,
    EV_EXPIRED   = 3'd4,
    EV_DROPPED   = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_SHRD,
    ST_SHWR,
    ST_EXPRD,
    ST_EXPCK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]  peer;
    logic [15:0] timeout;
    logic [7:0]  good;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [31:0] ses;
    logic [31:0] seq;
    logic [7:0]  typ;
    logic [7:0]  st;
  } item_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [31:0] ses;
    logic [31:0] seq;
    logic [7:0]  typ;
    logic [7:0]  st;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [23:0] ids;
    logic [31:0] ses;
    logic [31:0] seq;
    logic [31:0] tim;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [PW-1:0] phys_idx(logic [PW-1:0] head, logic [PW-1:0] j);
    logic [PW:0] s;
    s = {1'b0, head} + {1'b0, j};
    if (s >= (PW+1)'(TABLE_DEPTH)) s = s - (PW+1)'(TABLE_DEPTH);
    return s[PW-1:0];
  endfunction

endpackage

[sv/oat_ram.sv]
module oat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[sv/oat_engine.sv]
`include "outstanding_ack_tracker_assert.svh"

module oat_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  oat_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  oat_pkg::item_t             in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output oat_pkg::res_t              out_res,
  output logic                       ram_we,
  output logic [oat_pkg::PW-1:0]     ram_waddr,
  output logic [oat_pkg::ENTRY_W-1:0] ram_wdata,
  output logic [oat_pkg::PW-1:0]     ram_raddr,
  input  logic [oat_pkg::ENTRY_W-1:0] ram_rdata
);

  oat_pkg::state_t state_r, state_nxt;
  logic [oat_pkg::PW-1:0] head_r, head_nxt;
  logic [oat_pkg::CW-1:0] count_r, count_nxt;
  logic [31:0] time_r, time_nxt;
  logic [oat_pkg::PW-1:0] idx_r, idx_nxt;
  logic [oat_pkg::NW-1:0] n_r, n_nxt;
  logic pend_r, pend_nxt;
  oat_pkg::item_t item_r, item_nxt;
  oat_pkg::res_t res_r, res_nxt;
  logic ov_r, ov_nxt;
  oat_pkg::res_t o_r, o_nxt;

  oat_pkg::entry_t rd, wr;
  logic in_fire, slot_free, is_last, is_last2, match, due, table_full;
  logic [23:0] want;
  logic [31:0] age;
  logic [oat_pkg::PW-1:0] idx_p1;

  assign rd = oat_pkg::entry_t'(ram_rdata);
  assign ram_wdata = wr;
  assign in_ready = (state_r == oat_pkg::ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign slot_free = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_res = o_r;
  assign idx_p1 = idx_r + oat_pkg::PW'(1);
  assign is_last = (oat_pkg::CW'(idx_r) + oat_pkg::CW'(1)) == count_r;
  assign is_last2 = (oat_pkg::CW'(idx_r) + oat_pkg::CW'(2)) == count_r;
  assign table_full = count_r >= oat_pkg::CW'(oat_pkg::TABLE_DEPTH);
  assign want = {item_r.typ, item_r.src, item_r.dst};
  assign match = (rd.ids == want) && (rd.ses == item_r.ses) && (rd.seq == item_r.seq);
  assign age = time_r - rd.tim;
  assign due = age >= {16'd0, cfg.timeout};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oat_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_item.mode)
            oat_pkg::MODE_SENT: state_nxt = oat_pkg::ST_EMIT;
            oat_pkg::MODE_ACK:
              state_nxt = (count_r == '0) ? oat_pkg::ST_EMIT : oat_pkg::ST_SRD;
            oat_pkg::MODE_TICK: state_nxt = oat_pkg::ST_EXPRD;
            default: state_nxt = oat_pkg::ST_IDLE;
          endcase
        end
      end
      oat_pkg::ST_SRD: state_nxt = oat_pkg::ST_SCMP;
      oat_pkg::ST_SCMP: begin
        if (match) state_nxt = is_last ? oat_pkg::ST_EMIT : oat_pkg::ST_SHRD;
        else state_nxt = is_last ? oat_pkg::ST_EMIT : oat_pkg::ST_SRD;
      end
      oat_pkg::ST_SHRD: state_nxt = oat_pkg::ST_SHWR;
      oat_pkg::ST_SHWR: state_nxt = is_last2 ? oat_pkg::ST_EMIT : oat_pkg::ST_SHRD;
      oat_pkg::ST_EXPRD: begin
        if (count_r != '0 && n_r < oat_pkg::NW'(oat_pkg::MAX_RES))
          state_nxt = oat_pkg::ST_EXPCK;
        else state_nxt = pend_r ? oat_pkg::ST_EMIT : oat_pkg::ST_IDLE;
      end
      oat_pkg::ST_EXPCK: begin
        if (!due) state_nxt = pend_r ? oat_pkg::ST_EMIT : oat_pkg::ST_IDLE;
        else if (!pend_r || slot_free) state_nxt = oat_pkg::ST_EXPRD;
      end
      oat_pkg::ST_EMIT: if (slot_free) state_nxt = oat_pkg::ST_IDLE;
      default: state_nxt = oat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt = head_r;
    count_nxt = count_r;
    time_nxt = time_r;
    idx_nxt = idx_r;
    n_nxt = n_r;
    pend_nxt = pend_r;
    item_nxt = item_r;
    res_nxt = res_r;
    ov_nxt = ov_r && !out_ready;
    o_nxt = o_r;
    ram_we = 1'b0;
    ram_waddr = oat_pkg::phys_idx(head_r, idx_r);
    ram_raddr = oat_pkg::phys_idx(head_r, idx_r);
    wr = rd;
    case (state_r)
      oat_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_nxt = in_item;
          idx_nxt = '0;
          n_nxt = '0;
          pend_nxt = 1'b0;
          res_nxt.ses = in_item.ses;
          res_nxt.seq = in_item.seq;
          res_nxt.typ = in_item.typ;
          res_nxt.st = 8'd0;
          res_nxt.last = 1'b1;
          res_nxt.ev = oat_pkg::EV_DROPPED;
          case (in_item.mode)
            oat_pkg::MODE_SENT: begin
              if (!table_full) begin
                ram_we = 1'b1;
                ram_waddr = oat_pkg::phys_idx(head_r, oat_pkg::PW'(count_r));
                wr.ids = {in_item.typ, cfg.peer, in_item.src};
                wr.ses = in_item.ses;
                wr.seq = in_item.seq;
                wr.tim = time_r;
                count_nxt = count_r + oat_pkg::CW'(1);
                res_nxt.ev = oat_pkg::EV_QUEUED;
              end
            end
            oat_pkg::MODE_ACK: begin
              res_nxt.ev = oat_pkg::EV_UNMATCHED;
              res_nxt.st = in_item.st;
            end
            oat_pkg::MODE_TICK: time_nxt = time_r + 32'd1;
            default: ;
          endcase
        end
      end
      oat_pkg::ST_SCMP: begin
        if (match) begin
          res_nxt.ev = (item_r.st == cfg.good) ? oat_pkg::EV_OK : oat_pkg::EV_BAD;
          if (is_last) count_nxt = count_r - oat_pkg::CW'(1);
        end else if (!is_last) begin
          idx_nxt = idx_p1;
        end
      end
      oat_pkg::ST_SHRD: ram_raddr = oat_pkg::phys_idx(head_r, idx_p1);
      oat_pkg::ST_SHWR: begin
        ram_we = 1'b1;
        wr = rd;
        if (is_last2) count_nxt = count_r - oat_pkg::CW'(1);
        else idx_nxt = idx_p1;
      end
      oat_pkg::ST_EXPCK: begin
        if (due && (!pend_r || slot_free)) begin
          if (pend_r) begin
            ov_nxt = 1'b1;
            o_nxt = res_r;
            o_nxt.last = 1'b0;
          end
          res_nxt.ev = oat_pkg::EV_EXPIRED;
          res_nxt.ses = rd.ses;
          res_nxt.seq = rd.seq;
          res_nxt.typ = rd.ids[23:16];
          res_nxt.st = 8'd0;
          res_nxt.last = 1'b1;
          pend_nxt = 1'b1;
          head_nxt = oat_pkg::phys_idx(head_r, oat_pkg::PW'(1));
          count_nxt = count_r - oat_pkg::CW'(1);
          n_nxt = n_r + oat_pkg::NW'(1);
        end
      end
      oat_pkg::ST_EMIT: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          o_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oat_pkg::ST_IDLE;
      head_r <= '0;
      count_r <= '0;
      time_r <= '0;
      idx_r <= '0;
      n_r <= '0;
      pend_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      count_r <= count_nxt;
      time_r <= time_nxt;
      idx_r <= idx_nxt;
      n_r <= n_nxt;
      pend_r <= pend_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r <= res_nxt;
    o_r <= o_nxt;
  end

  `OAT_ASSERT(a_count_bound, count_r <= oat_pkg::CW'(oat_pkg::TABLE_DEPTH), "table count overflow")
  `OAT_ASSERT(a_n_bound, n_r <= oat_pkg::NW'(oat_pkg::MAX_RES), "too many expiries")
  `OAT_ASSERT(a_sent_grows, in_fire && in_item.mode == oat_pkg::MODE_SENT && !table_full |=> count_r == $past(count_r) + oat_pkg::CW'(1), "sent request not stored")
  `OAT_ASSERT(a_tick_time, in_fire && in_item.mode == oat_pkg::MODE_TICK |=> time_r == $past(time_r) + 32'd1, "tick did not advance time")
  `OAT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == oat_pkg::ST_IDLE && !ov_r, "reset left block busy")

endmodule

[sv/outstanding_ack_tracker.sv]
// Tracks up to 16 outstanding requests in a ring table held in one synchronous RAM.
// A sent request is stored in the table when it has room, and its result is then emitted. An
// acknowledgement scans the table oldest first, with a read and a compare per entry.
// On a match it moves each younger entry down, with a read and a write per entry. A
// tick reads and checks entries oldest first. It ends from the read step when the
// table runs out or 16 entries have expired, or from the check when an entry is not
// due, and then emits if it has results. Entries are read one at a time through the
// single RAM read port, and a stalled output delays each result's hand-over. A new
// request is taken once the previous one has handed its last result to the output
// register. A result waiting in the output register does not block acceptance.
module outstanding_ack_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_src_id,
  input  logic [7:0]  in_dst_id,
  input  logic [31:0] in_session_id,
  input  logic [31:0] in_sequence_req,
  input  logic [7:0]  in_msg_type,
  input  logic [7:0]  in_ack_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [31:0] out_session,
  output logic [31:0] out_sequence,
  output logic [7:0]  out_type,
  output logic [7:0]  out_status,
  output logic        out_last
);

  oat_pkg::cfg_t cfg_r, cfg_nxt;
  oat_pkg::item_t item;
  oat_pkg::res_t res;
  logic ram_we;
  logic [oat_pkg::PW-1:0] ram_waddr, ram_raddr;
  logic [oat_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        oat_pkg::REG_PEER:    cfg_nxt.peer = cfg_data[7:0];
        oat_pkg::REG_TIMEOUT: cfg_nxt.timeout = cfg_data;
        oat_pkg::REG_GOOD:    cfg_nxt.good = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peer <= oat_pkg::PEER_RESET;
      cfg_r.timeout <= oat_pkg::TIMEOUT_RESET;
      cfg_r.good <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign item.mode = in_mode;
  assign item.src = in_src_id;
  assign item.dst = in_dst_id;
  assign item.ses = in_session_id;
  assign item.seq = in_sequence_req;
  assign item.typ = in_msg_type;
  assign item.st = in_ack_status;

  assign out_event_res = res.ev;
  assign out_session = res.ses;
  assign out_sequence = res.seq;
  assign out_type = res.typ;
  assign out_status = res.st;
  assign out_last = res.last;

  oat_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  oat_ram #(
    .WIDTH (oat_pkg::ENTRY_W),
    .DEPTH (oat_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[dv/tb_outstanding_ack_tracker.sv]
module tb_outstanding_ack_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int N_RANDOM = 360;
  localparam int N_PHASES = 6;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    oat_pkg::item_t  it;
    bit              typed;
    oat_pkg::event_t ev;
    logic [7:0]      st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_src_id = '0;
  logic [7:0]  in_dst_id = '0;
  logic [31:0] in_session_id = '0;
  logic [31:0] in_sequence_req = '0;
  logic [7:0]  in_msg_type = '0;
  logic [7:0]  in_ack_status = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_res;
  logic [31:0] out_session;
  logic [31:0] out_sequence;
  logic [7:0]  out_type;
  logic [7:0]  out_status;
  logic        out_last;

  outstanding_ack_tracker uut (.*);

  always #5 clk = ~clk;

  // tracker model state
  oat_pkg::entry_t pend_tbl[oat_pkg::TABLE_DEPTH];
  int          pend_cnt;
  logic [31:0] tick_now;
  logic [7:0]  cfg_peer;
  logic [15:0] cfg_timeout;
  logic [7:0]  cfg_good;

  oat_pkg::res_t fresh_res[$];
  oat_pkg::res_t awaited_res[$];
  int          errors = 0;
  row_t        rows[$];
  int          burst_left = 0;
  int          rcv_cyc = 0;

  task automatic mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic drop_entry(input int idx);
    for (int i = idx; i + 1 < pend_cnt; i++) pend_tbl[i] = pend_tbl[i + 1];
    pend_cnt--;
  endtask

  task automatic push_fresh(input oat_pkg::event_t ev, input logic [31:0] ses,
                            input logic [31:0] seq, input logic [7:0] typ,
                            input logic [7:0] st);
    oat_pkg::res_t r;
    r.ev = ev; r.ses = ses; r.seq = seq; r.typ = typ; r.st = st; r.last = 1'b0;
    fresh_res = {fresh_res, r};
  endtask

  task automatic track_request(input oat_pkg::item_t it);
    logic [23:0] want;
    logic [31:0] age;
    int hit;
    fresh_res.delete();
    case (it.mode)
      oat_pkg::MODE_SENT: begin
        if (pend_cnt < oat_pkg::TABLE_DEPTH) begin
          pend_tbl[pend_cnt] = '{ids: {it.typ, cfg_peer, it.src}, ses: it.ses, seq: it.seq,
                                 tim: tick_now};
          pend_cnt++;
          push_fresh(oat_pkg::EV_QUEUED, it.ses, it.seq, it.typ, 8'h00);
        end else begin
          push_fresh(oat_pkg::EV_DROPPED, it.ses, it.seq, it.typ, 8'h00);
        end
      end
      oat_pkg::MODE_ACK: begin
        want = {it.typ, it.src, it.dst};
        hit = -1;
        for (int i = 0; i < pend_cnt; i++)
          if (hit < 0 && pend_tbl[i].ids == want && pend_tbl[i].ses == it.ses &&
              pend_tbl[i].seq == it.seq) hit = i;
        if (hit >= 0) begin
          drop_entry(hit);
          push_fresh(it.st == cfg_good ? oat_pkg::EV_OK : oat_pkg::EV_BAD, it.ses, it.seq,
                     it.typ, it.st);
        end else begin
          push_fresh(oat_pkg::EV_UNMATCHED, it.ses, it.seq, it.typ, it.st);
        end
      end
      oat_pkg::MODE_TICK: begin
        tick_now = tick_now + 32'd1;
        age = tick_now - pend_tbl[0].tim;
        while (pend_cnt > 0 && fresh_res.size() < oat_pkg::MAX_RES &&
               age >= {16'd0, cfg_timeout}) begin
          push_fresh(oat_pkg::EV_EXPIRED, pend_tbl[0].ses, pend_tbl[0].seq,
                     pend_tbl[0].ids[23:16], 8'h00);
          drop_entry(0);
          age = tick_now - pend_tbl[0].tim;
        end
      end
      default: ;
    endcase
    if (fresh_res.size() > 0) fresh_res[fresh_res.size() - 1].last = 1'b1;
  endtask

  task automatic send_request(input oat_pkg::item_t it);
    in_valid        <= 1'b1;
    in_mode         <= it.mode;
    in_src_id       <= it.src;
    in_dst_id       <= it.dst;
    in_session_id   <= it.ses;
    in_sequence_req <= it.seq;
    in_msg_type     <= it.typ;
    in_ack_status   <= it.st;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      oat_pkg::REG_PEER:    cfg_peer = val[7:0];
      oat_pkg::REG_TIMEOUT: cfg_timeout = val;
      oat_pkg::REG_GOOD:    cfg_good = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited_res.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input oat_pkg::mode_t m, input logic [7:0] src, input logic [7:0] dst,
                         input logic [31:0] ses, input logic [31:0] seq, input logic [7:0] typ,
                         input logic [7:0] st, input bit typed, input oat_pkg::event_t ev);
    row_t r;
    r.it = '{mode: m, src: src, dst: dst, ses: ses, seq: seq, typ: typ, st: st};
    r.typed = typed;
    r.ev = ev;
    r.st = (ev == oat_pkg::EV_QUEUED) ? 8'h00 : st;
    rows = {rows, r};
  endtask

  function automatic oat_pkg::item_t random_request();
    oat_pkg::item_t it;
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    it.src = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    it.dst = 8'($urandom);
    it.ses = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 2));
    it.seq = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 3));
    it.typ = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
    it.st  = ($urandom_range(0, 1) == 0) ? cfg_good : 8'($urandom);
    if (pick < 40) begin
      it.mode = oat_pkg::MODE_SENT;
    end else if (pick < 75) begin
      it.mode = oat_pkg::MODE_ACK;
      if (pend_cnt > 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, pend_cnt - 1);
        it.src = pend_tbl[k].ids[15:8];
        it.dst = pend_tbl[k].ids[7:0];
        it.typ = pend_tbl[k].ids[23:16];
        it.ses = pend_tbl[k].ses;
        it.seq = pend_tbl[k].seq;
      end else if ($urandom_range(0, 1) == 0) begin
        it.src = cfg_peer;
      end
    end else if (pick < 95) begin
      it.mode = oat_pkg::MODE_TICK;
    end else begin
      it.mode = oat_pkg::MODE_NONE;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rcv_cyc <= rcv_cyc + 1;
      case ((rcv_cyc / 200) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    oat_pkg::res_t w;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_res.size() == 0) begin
        mismatch("unexpected result event", 32'(out_event_res), 32'hx);
      end else begin
        w = awaited_res[0];
        awaited_res.delete(0);
        if (out_event_res !== w.ev) mismatch("event", 32'(out_event_res), 32'(w.ev));
        if (out_session !== w.ses) mismatch("session", out_session, w.ses);
        if (out_sequence !== w.seq) mismatch("sequence", out_sequence, w.seq);
        if (out_type !== w.typ) mismatch("type", 32'(out_type), 32'(w.typ));
        if (out_status !== w.st) mismatch("status", 32'(out_status), 32'(w.st));
        if (out_last !== w.last) mismatch("last", 32'(out_last), 32'(w.last));
      end
    end
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    oat_pkg::item_t it;
    oat_pkg::res_t r;
    cfg_peer = oat_pkg::PEER_RESET;
    cfg_timeout = oat_pkg::TIMEOUT_RESET;
    cfg_good = 8'h00;
    pend_cnt = 0;
    tick_now = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every mode, full table
    add_row(oat_pkg::MODE_SENT, 8'h00, 8'h00, 32'h0, 32'h0, 8'h00, 8'h00, 1,
            oat_pkg::EV_QUEUED);
    add_row(oat_pkg::MODE_SENT, 8'hFF, 8'hFF, '1, '1, 8'hFF, 8'hFF, 1, oat_pkg::EV_QUEUED);
    add_row(oat_pkg::MODE_ACK, 8'hF0, 8'hFF, '1, '1, 8'hFF, 8'h00, 1, oat_pkg::EV_OK);
    add_row(oat_pkg::MODE_ACK, 8'h01, 8'h02, 32'h1234, 32'h5678, 8'h11, 8'hAA, 1,
            oat_pkg::EV_UNMATCHED);
    add_row(oat_pkg::MODE_ACK, 8'hF0, 8'h00, 32'h0, 32'h0, 8'h00, 8'h55, 1, oat_pkg::EV_BAD);
    add_row(oat_pkg::MODE_NONE, 8'hFF, 8'hFF, '1, '1, 8'hFF, 8'hFF, 0, oat_pkg::EV_QUEUED);
    add_row(oat_pkg::MODE_TICK, 8'h00, 8'h00, 32'h0, 32'h0, 8'h00, 8'h00, 0,
            oat_pkg::EV_QUEUED);
    for (int i = 0; i < oat_pkg::TABLE_DEPTH + 1; i++)
      add_row(oat_pkg::MODE_SENT, 8'(i), 8'h00, 32'(i), 32'(i * 3), 8'(i), 8'h00, 0,
              oat_pkg::EV_QUEUED);
    foreach (rows[i]) begin
      track_request(rows[i].it);
      if (rows[i].typed) begin
        r = '{ev: rows[i].ev, ses: rows[i].it.ses, seq: rows[i].it.seq, typ: rows[i].it.typ,
              st: rows[i].st, last: 1'b1};
        awaited_res = {awaited_res, r};
      end else begin
        awaited_res = {awaited_res, fresh_res};
      end
      send_request(rows[i].it);
    end

    // full table expiring in one tick
    drain_and_settle();
    write_reg(oat_pkg::REG_TIMEOUT, 16'd1);
    it = '{mode: oat_pkg::MODE_TICK, default: '0};
    track_request(it);
    awaited_res = {awaited_res, fresh_res};
    send_request(it);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_and_settle();
      case (p)
        0: begin
          write_reg(oat_pkg::REG_PEER, 16'h0000);
          write_reg(oat_pkg::REG_TIMEOUT, 16'd0);
          write_reg(oat_pkg::REG_GOOD, 16'hFFFF);
        end
        1: begin
          write_reg(oat_pkg::REG_PEER, 16'hFFFF);
          write_reg(oat_pkg::REG_TIMEOUT, 16'd65535);
          write_reg(oat_pkg::REG_GOOD, 16'h0000);
          write_reg(REG_UNUSED, 16'hFFFF);
        end
        2: begin
          write_reg(oat_pkg::REG_PEER, 16'($urandom));
          write_reg(oat_pkg::REG_TIMEOUT, 16'd60000);
        end
        default: begin
          write_reg(oat_pkg::REG_PEER, 16'($urandom));
          write_reg(oat_pkg::REG_TIMEOUT, 16'($urandom_range(1, 12)));
          write_reg(oat_pkg::REG_GOOD, 16'($urandom));
        end
      endcase
      for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
        it = random_request();
        track_request(it);
        awaited_res = {awaited_res, fresh_res};
        send_request(it);
      end
    end

    in_valid <= 1'b0;
    while (awaited_res.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
